/* rtl/sorted_list_table_macros.svh */
// ----------------------------------------------------------------------------
// sorted_list_table assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// same-cycle implication
`define SLT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_list_table assertion failed");

// next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_list_table assertion failed");

`endif

/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and sizes for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY = 64;
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int STAT_W   = 2;
	localparam int ECOUNT_W = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_READ       = 3'd2,
		CMD_REMOVE_AT  = 3'd3,
		CMD_REMOVE_VAL = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_FIND,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic                       use_gt;
		logic signed [VALUE_W-1:0]  key;
		logic [WIDE_W-1:0]          tgt;
		logic [CNT_W-1:0]           count;
	} cell_ctl_t;

	typedef struct packed {
		logic             any;
		logic [IDX_W-1:0] idx;
	} hit_t;

endpackage

/* rtl/slt_if.sv */
// ----------------------------------------------------------------------------
// slt_req_if / slt_rsp_if
// Valid/ready channels for table requests and their results.
// ----------------------------------------------------------------------------
interface slt_req_if import slt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] result_value;
	logic [POS_W-1:0]          result_position;
	logic [STAT_W-1:0]         status;
	logic [ECOUNT_W-1:0]       entry_count;

	modport source (output valid, result_value, result_position, status, entry_count,
		input ready);
	modport sink (input valid, result_value, result_position, status, entry_count,
		output ready);
endinterface

/* rtl/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell
// One table slot: holds an entry, compares it against the key and shifts
// to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module slt_cell import slt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [WIDE_W-1:0]         index,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] prev_value,
	input  logic signed [VALUE_W-1:0] next_value,
	output logic signed [VALUE_W-1:0] value,
	output logic                      flag,
	output logic signed [VALUE_W-1:0] tap
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      flag_q;
	logic                      occupied;
	logic                      hit;

	assign occupied = index < WIDE_W'(ctl.count);
	assign hit      = ctl.use_gt ? (value_q > ctl.key) : (value_q == ctl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.op == CELL_CMP) begin
			flag_q <= occupied & hit;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_INS: begin
				if (index > ctl.tgt) begin
					value_q <= prev_value;
				end else if (index == ctl.tgt) begin
					value_q <= ctl.key;
				end
			end
			CELL_REM: begin
				if (index >= ctl.tgt) begin
					value_q <= next_value;
				end
			end
			CELL_HOLD, CELL_CMP: begin
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign flag  = flag_q;
	assign tap   = (index == ctl.tgt) ? value_q : '0;

endmodule

/* rtl/slt_find.sv */
// ----------------------------------------------------------------------------
// slt_find
// Registered find-first over the cell flags: lowest flagged index.
// ----------------------------------------------------------------------------
module slt_find import slt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                capture,
	input  logic [CAPACITY-1:0] flags,
	output hit_t                hit
);

	logic [CAPACITY-1:0] lowest;
	logic [IDX_W-1:0]    enc;
	hit_t                hit_q;

	assign lowest = flags & (~flags + CAPACITY'(1));

	always_comb begin
		enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lowest[i]) begin
				enc = enc | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (capture) begin
			hit_q.any <= |flags;
			hit_q.idx <= enc;
		end
	end

	assign hit = hit_q;

endmodule

/* rtl/sorted_list_table.sv */
// ----------------------------------------------------------------------------
// sorted_list_table
// Ascending table of up to CAPACITY signed 32-bit entries in a row of cells.
// Requests arrive on req (cmd, value, position) and one result leaves on rsp
// per request (result_value, result_position, status, entry_count).
// A request runs through its steps in order: accept, compare in every cell,
// find-first of the cell flags, then apply the shift and load the result
// register. The result is valid the cycle after that load; a new request
// is taken only once the previous one has left its last step.
// req.ready is high while no request is in work; a new request is taken while
// the previous result still waits on rsp. If rsp stalls, the block holds the
// finished request in its last step until the result register frees up.
// Reset empties the table (count zero) and drops any pending result; cell
// contents are left as they are and only entries below the count are read.
// ----------------------------------------------------------------------------
`include "sorted_list_table_macros.svh"

module sorted_list_table import slt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	slt_req_if.sink   req,
	slt_rsp_if.source rsp
);

	state_t                    state_q, state_d;
	cmd_t                      cmd_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]          pos_q;
	logic [CNT_W-1:0]          count_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [POS_W-1:0]          out_pos_q;
	status_t                   out_stat_q;
	logic [ECOUNT_W-1:0]       out_count_q;

	logic                      accept;
	logic                      slot_free;
	logic                      load_out;

	cell_ctl_t                 ctl;
	hit_t                      hit;
	logic [CAPACITY-1:0]       flags;
	logic signed [VALUE_W-1:0] cell_value [CAPACITY];
	logic signed [VALUE_W-1:0] cell_tap [CAPACITY];
	logic signed [VALUE_W-1:0] rd_bus;

	cell_op_t                  exec_op;
	logic [WIDE_W-1:0]         exec_tgt;
	status_t                   exec_stat;
	logic                      exec_take;
	logic [CNT_W-1:0]          exec_cnt;
	logic                      full;
	logic [WIDE_W-1:0]         pos_w;
	logic [WIDE_W-1:0]         cnt_w;

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign load_out  = (state_q == ST_EXEC) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP:  state_d = ST_FIND;
			ST_FIND: state_d = ST_EXEC;
			ST_EXEC: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(req.cmd);
			val_q <= req.value;
			pos_q <= req.position;
		end
	end

	// decide the table operation from the request and the search result
	always_comb begin
		full      = count_q == CNT_W'(CAPACITY);
		pos_w     = WIDE_W'(pos_q);
		cnt_w     = WIDE_W'(count_q);
		exec_op   = CELL_HOLD;
		exec_tgt  = '0;
		exec_stat = STAT_OK;
		exec_take = 1'b0;
		exec_cnt  = count_q;
		unique case (cmd_q)
			CMD_ADD: begin
				if (full) begin
					exec_stat = STAT_FULL;
				end else begin
					exec_op  = CELL_INS;
					exec_tgt = hit.any ? WIDE_W'(hit.idx) : cnt_w;
					exec_cnt = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					exec_stat = STAT_FULL;
				end else if (pos_w > cnt_w) begin
					exec_stat = STAT_RANGE;
				end else begin
					exec_op  = CELL_INS;
					exec_tgt = pos_w;
					exec_cnt = count_q + CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (pos_w >= cnt_w) begin
					exec_stat = STAT_RANGE;
				end else begin
					exec_tgt  = pos_w;
					exec_take = 1'b1;
				end
			end
			CMD_REMOVE_AT: begin
				if (pos_w >= cnt_w) begin
					exec_stat = STAT_RANGE;
				end else begin
					exec_op   = CELL_REM;
					exec_tgt  = pos_w;
					exec_take = 1'b1;
					exec_cnt  = count_q - CNT_W'(1);
				end
			end
			CMD_REMOVE_VAL: begin
				if (hit.any) begin
					exec_op   = CELL_REM;
					exec_tgt  = WIDE_W'(hit.idx);
					exec_take = 1'b1;
					exec_cnt  = count_q - CNT_W'(1);
				end else begin
					exec_stat = STAT_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl.use_gt = cmd_q == CMD_ADD;
		ctl.key    = val_q;
		ctl.tgt    = exec_tgt;
		ctl.count  = count_q;
		if (state_q == ST_CMP) begin
			ctl.op = CELL_CMP;
		end else if (load_out) begin
			ctl.op = exec_op;
		end else begin
			ctl.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_v;
		logic signed [VALUE_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = '0;
		end else begin : g_prev
			assign prev_v = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_next
			assign next_v = cell_value[i+1];
		end

		slt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.index      (WIDE_W'(i)),
			.ctl        (ctl),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_value[i]),
			.flag       (flags[i]),
			.tap        (cell_tap[i])
		);
	end

	slt_find u_find (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (state_q == ST_FIND),
		.flags   (flags),
		.hit     (hit)
	);

	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				count_q     <= exec_cnt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= exec_take ? rd_bus : '0;
			out_pos_q   <= POS_W'(exec_tgt);
			out_stat_q  <= exec_stat;
			out_count_q <= ECOUNT_W'(exec_cnt);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.result_value    = out_value_q;
	assign rsp.result_position = out_pos_q;
	assign rsp.status          = out_stat_q;
	assign rsp.entry_count     = out_count_q;

	`SLT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SLT_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_CMP)
	`SLT_ASSERT_NEXT(a_error_keeps_count, load_out && exec_stat != STAT_OK, $stable(count_q))
	`SLT_ASSERT_IMPL(a_result_from_exec, $rose(out_valid_q), $past(state_q) == ST_EXEC)

endmodule
